### src/vfps_pkg.sv
package vfps_pkg;

   // pressure and setpoint width, millibar, unsigned
   localparam int PRESSURE_BITS = 16;

   // command codes
   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_HOLD   = 3'd1;
   localparam logic [2:0] OP_STOP   = 3'd2;
   localparam logic [2:0] OP_RESET  = 3'd3;
   localparam logic [2:0] OP_RESUME = 3'd4;
   localparam logic [2:0] OP_TICK   = 3'd5;

   // phase codes
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_EXEC      = 4'd1;
   localparam logic [3:0] PH_RESUMING  = 4'd2;
   localparam logic [3:0] PH_HOLDING   = 4'd3;
   localparam logic [3:0] PH_HELD      = 4'd4;
   localparam logic [3:0] PH_STOPPING  = 4'd5;
   localparam logic [3:0] PH_STOPPED   = 4'd6;
   localparam logic [3:0] PH_COMPLETE  = 4'd7;
   localparam logic [3:0] PH_RESETTING = 4'd8;

   // execution steps
   localparam logic [1:0] STEP_OPEN  = 2'd0;
   localparam logic [1:0] STEP_FILL  = 2'd1;
   localparam logic [1:0] STEP_CLOSE = 2'd2;

   typedef struct packed {
      logic [2:0]               opcode;
      logic [PRESSURE_BITS-1:0] setpoint_mbar;
      logic [PRESSURE_BITS-1:0] pressure_mbar;
      logic                     valve_is_open;
   } req_type;

   typedef struct packed {
      logic [3:0] phase_state;
      logic       valve_drive;
   } rsp_type;

   typedef struct packed {
      logic [3:0]               phase;
      logic [1:0]               exec_step;
      logic [PRESSURE_BITS-1:0] latched_setpoint;
      logic                     drive;
   } state_type;

endpackage

### src/vfps_in_stage.sv
module vfps_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vfps_pkg::req_type req_data,
   input  logic              take,
   output logic              hold_valid,
   output vfps_pkg::req_type hold_data
);

   logic              valid_ff, valid_in;
   vfps_pkg::req_type data_ff;

   // room when empty or when the held request leaves this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

### src/vfps_next_state.sv
module vfps_next_state (
   input  vfps_pkg::state_type cur,
   input  vfps_pkg::req_type   req,
   output vfps_pkg::state_type nxt
);

   logic pr_le_sp;
   logic pr_gt_latched;

   assign pr_le_sp      = req.pressure_mbar <= req.setpoint_mbar;
   assign pr_gt_latched = req.pressure_mbar > cur.latched_setpoint;

   always_comb begin
      nxt = cur;
      unique case (req.opcode)
         vfps_pkg::OP_START: begin
            if (cur.phase == vfps_pkg::PH_IDLE && pr_le_sp) begin
               nxt.latched_setpoint = req.setpoint_mbar;
               nxt.phase            = vfps_pkg::PH_EXEC;
            end
         end
         vfps_pkg::OP_HOLD: begin
            if (cur.phase == vfps_pkg::PH_EXEC) begin
               nxt.phase = vfps_pkg::PH_HOLDING;
            end
         end
         vfps_pkg::OP_STOP: begin
            if (cur.phase == vfps_pkg::PH_EXEC || cur.phase == vfps_pkg::PH_RESUMING ||
                cur.phase == vfps_pkg::PH_HOLDING || cur.phase == vfps_pkg::PH_HELD) begin
               nxt.phase = vfps_pkg::PH_STOPPING;
            end
         end
         vfps_pkg::OP_RESET: begin
            if (cur.phase == vfps_pkg::PH_STOPPED || cur.phase == vfps_pkg::PH_COMPLETE) begin
               nxt.phase = vfps_pkg::PH_RESETTING;
            end
         end
         vfps_pkg::OP_RESUME: begin
            if (cur.phase == vfps_pkg::PH_HELD) begin
               nxt.phase = vfps_pkg::PH_RESUMING;
            end
         end
         vfps_pkg::OP_TICK: begin
            // update tick walks the phase sequences
            unique case (cur.phase)
               vfps_pkg::PH_EXEC: begin
                  unique case (cur.exec_step)
                     vfps_pkg::STEP_OPEN: begin
                        nxt.drive = 1'b1;
                        if (req.valve_is_open) begin
                           nxt.exec_step = vfps_pkg::STEP_FILL;
                        end
                     end
                     vfps_pkg::STEP_FILL: begin
                        if (pr_gt_latched) begin
                           nxt.exec_step = vfps_pkg::STEP_CLOSE;
                        end
                     end
                     vfps_pkg::STEP_CLOSE: begin
                        nxt.drive = 1'b0;
                        if (!req.valve_is_open) begin
                           nxt.phase = vfps_pkg::PH_COMPLETE;
                        end
                     end
                     default: ;
                  endcase
               end
               vfps_pkg::PH_HOLDING: begin
                  nxt.drive = 1'b0;
                  if (!req.valve_is_open) begin
                     nxt.phase = vfps_pkg::PH_HELD;
                  end
               end
               vfps_pkg::PH_STOPPING: begin
                  nxt.drive = 1'b0;
                  if (!req.valve_is_open) begin
                     nxt.phase = vfps_pkg::PH_STOPPED;
                  end
               end
               vfps_pkg::PH_RESUMING: begin
                  nxt.exec_step = vfps_pkg::STEP_OPEN;
                  nxt.phase     = vfps_pkg::PH_EXEC;
               end
               vfps_pkg::PH_RESETTING: begin
                  nxt.exec_step = vfps_pkg::STEP_OPEN;
                  nxt.phase     = vfps_pkg::PH_IDLE;
               end
               vfps_pkg::PH_COMPLETE: begin
                  nxt.phase = vfps_pkg::PH_RESETTING;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

endmodule

### src/valve_fill_phase_sequencer_unit.sv
// Valve fill phase sequencer.
// Request channel (req_valid/req_ready/req_data): one command per request,
// start, hold, stop, reset, resume or update tick, with a pressure sample
// and valve feedback. Result channel (rsp_valid/rsp_ready/rsp_data): one
// result per request, the phase state and valve drive after that command.
// An accepted request is held in the request register, its next
// state is computed from the registered request and the phase registers,
// and the result is loaded into the output register once that register is
// free or its result is being taken; rsp_valid is registered with it.
// Throughput: one request per cycle while results are taken, set by the
// combinational next-state logic between request and phase/output registers.
// Reset (synchronous, active high) empties both registers and returns the
// phase to idle, step one, setpoint zero and valve closed.
// When the receiver stalls, the result holds in the output register; one
// more request is taken into the request register, and req_ready then
// drops until the result is taken.
module valve_fill_phase_sequencer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vfps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vfps_pkg::rsp_type rsp_data
);

   logic                hold_valid;
   vfps_pkg::req_type   hold_data;
   logic                advance;
   vfps_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   vfps_pkg::rsp_type   rsp_data_ff;

   // held request moves on when the output register is free
   assign advance = hold_valid && (!rsp_valid_ff || rsp_ready);

   vfps_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   vfps_next_state u_next_state (
      .cur (state_ff),
      .req (hold_data),
      .nxt (state_in)
   );

   // phase state, committed as the request leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase            <= vfps_pkg::PH_IDLE;
         state_ff.exec_step        <= vfps_pkg::STEP_OPEN;
         state_ff.latched_setpoint <= '0;
         state_ff.drive            <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.phase_state <= state_in.phase;
         rsp_data_ff.valve_drive <= state_in.drive;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/vfps_checker.sv
module vfps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input vfps_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // request side stays open while the output register can move
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request refused with the output free");

   // phase stays among the defined codes
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.phase_state <= vfps_pkg::PH_RESETTING)
      else $error("undefined phase reported");

   // valve can only be driven open while executing, holding or stopping
   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valve_drive |->
         rsp_data.phase_state == vfps_pkg::PH_EXEC ||
         rsp_data.phase_state == vfps_pkg::PH_HOLDING ||
         rsp_data.phase_state == vfps_pkg::PH_STOPPING)
      else $error("valve open in a closed-valve phase");

endmodule

bind valve_fill_phase_sequencer_unit vfps_checker u_vfps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/sv/tb_valve_fill_phase_sequencer_unit.sv
// Tracks the sequencer state and checks every result against it
class fill_phase_scoreboard;
   vfps_pkg::state_type st;
   vfps_pkg::rsp_type   expected_status_q[$];
   int                  failures;
   int                  results_checked;
   int                  fills_done;
   int                  op_seen[8];

   function new();
      st.phase            = vfps_pkg::PH_IDLE;
      st.exec_step        = vfps_pkg::STEP_OPEN;
      st.latched_setpoint = '0;
      st.drive            = 1'b0;
      failures            = 0;
      results_checked     = 0;
      fills_done          = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
   endfunction

   // Apply one accepted request and queue the phase/drive it should produce
   function void note_command(vfps_pkg::req_type r);
      vfps_pkg::rsp_type e;
      op_seen[r.opcode]++;
      case (r.opcode)
         vfps_pkg::OP_START: begin
            if (st.phase == vfps_pkg::PH_IDLE && r.pressure_mbar <= r.setpoint_mbar) begin
               st.latched_setpoint = r.setpoint_mbar;
               st.phase            = vfps_pkg::PH_EXEC;
            end
         end
         vfps_pkg::OP_HOLD: begin
            if (st.phase == vfps_pkg::PH_EXEC) st.phase = vfps_pkg::PH_HOLDING;
         end
         vfps_pkg::OP_STOP: begin
            if (st.phase inside {vfps_pkg::PH_EXEC, vfps_pkg::PH_RESUMING,
                                 vfps_pkg::PH_HOLDING, vfps_pkg::PH_HELD})
               st.phase = vfps_pkg::PH_STOPPING;
         end
         vfps_pkg::OP_RESET: begin
            if (st.phase == vfps_pkg::PH_STOPPED || st.phase == vfps_pkg::PH_COMPLETE)
               st.phase = vfps_pkg::PH_RESETTING;
         end
         vfps_pkg::OP_RESUME: begin
            if (st.phase == vfps_pkg::PH_HELD) st.phase = vfps_pkg::PH_RESUMING;
         end
         vfps_pkg::OP_TICK: begin
            case (st.phase)
               vfps_pkg::PH_EXEC: begin
                  case (st.exec_step)
                     vfps_pkg::STEP_OPEN: begin
                        st.drive = 1'b1;
                        if (r.valve_is_open) st.exec_step = vfps_pkg::STEP_FILL;
                     end
                     vfps_pkg::STEP_FILL: begin
                        if (r.pressure_mbar > st.latched_setpoint)
                           st.exec_step = vfps_pkg::STEP_CLOSE;
                     end
                     vfps_pkg::STEP_CLOSE: begin
                        st.drive = 1'b0;
                        if (!r.valve_is_open) begin
                           st.phase = vfps_pkg::PH_COMPLETE;
                           fills_done++;
                        end
                     end
                     default: ;
                  endcase
               end
               vfps_pkg::PH_HOLDING: begin
                  st.drive = 1'b0;
                  if (!r.valve_is_open) st.phase = vfps_pkg::PH_HELD;
               end
               vfps_pkg::PH_STOPPING: begin
                  st.drive = 1'b0;
                  if (!r.valve_is_open) st.phase = vfps_pkg::PH_STOPPED;
               end
               vfps_pkg::PH_RESUMING: begin
                  st.exec_step = vfps_pkg::STEP_OPEN;
                  st.phase     = vfps_pkg::PH_EXEC;
               end
               vfps_pkg::PH_RESETTING: begin
                  st.exec_step = vfps_pkg::STEP_OPEN;
                  st.phase     = vfps_pkg::PH_IDLE;
               end
               vfps_pkg::PH_COMPLETE: st.phase = vfps_pkg::PH_RESETTING;
               default: ;
            endcase
         end
         // spare opcodes are ignored
         default: ;
      endcase
      e.phase_state = st.phase;
      e.valve_drive = st.drive;
      expected_status_q.push_back(e);
   endfunction

   // Compare one result with the oldest expectation
   function void check_result(vfps_pkg::rsp_type got);
      vfps_pkg::rsp_type e;
      if (expected_status_q.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected result: phase %0d drive %0b", got.phase_state,
                     got.valve_drive);
         return;
      end
      e = expected_status_q.pop_front();
      results_checked++;
      if (got.phase_state !== e.phase_state || got.valve_drive !== e.valve_drive) begin
         failures++;
         if (failures <= 10)
            $display("result %0d mismatch: phase exp %0d got %0d, drive exp %0b got %0b",
                     results_checked, e.phase_state, got.phase_state, e.valve_drive,
                     got.valve_drive);
      end
   endfunction

   function int pending();
      return expected_status_q.size();
   endfunction
endclass

module tb_valve_fill_phase_sequencer_unit;

   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;
   localparam int RANDOM_ITEMS = 1600;
   localparam int IDLE_LIMIT   = 4000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   vfps_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   vfps_pkg::rsp_type rsp_data;

   fill_phase_scoreboard sb;

   int burst_left;
   int stall_mode;
   int stall_left;
   int stall_cycle;
   int quiet_cycles;
   int total_items;
   int active_items;

   valve_fill_phase_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_command(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // Watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("valve_fill_phase_sequencer_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result-side backpressure, switching between patterns
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_cycle++;
      case (stall_mode)
         0:       rsp_ready = 1'b1;
         1:       rsp_ready = ($urandom_range(0, 9) < 7);
         2:       rsp_ready = (stall_cycle % 4 != 0);
         default: rsp_ready = ($urandom_range(0, 3) == 0);
      endcase
   end

   // Drive one request in bursts; returns at the falling edge after acceptance
   task automatic push_request(input vfps_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      total_items++;
   endtask

   task automatic send_cmd(input logic [2:0] op, input logic [15:0] sp,
                           input logic [15:0] pr, input logic fb);
      vfps_pkg::req_type r;
      r.opcode        = op;
      r.setpoint_mbar = sp;
      r.pressure_mbar = pr;
      r.valve_is_open = fb;
      push_request(r);
   endtask

   // Hold off new requests until every result is back
   task automatic drain_results();
      req_valid  = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Mostly well-formed fill sequences, with some noise
   function automatic vfps_pkg::req_type pick_command();
      vfps_pkg::req_type r;
      int                roll;
      roll = $urandom_range(0, 99);
      r.setpoint_mbar = (roll < 10) ? 16'h0000 : (roll < 20) ? 16'hFFFF : 16'($urandom);
      r.pressure_mbar = 16'($urandom);
      r.valve_is_open = ($urandom_range(0, 3) != 0) ? sb.st.drive : ~sb.st.drive;
      r.opcode        = vfps_pkg::OP_TICK;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         r.opcode = 3'($urandom_range(0, 7));
         return r;
      end
      case (sb.st.phase)
         vfps_pkg::PH_IDLE: begin
            if (roll < 75) begin
               r.opcode = vfps_pkg::OP_START;
               if (roll < 65) r.pressure_mbar = 16'($urandom_range(0, r.setpoint_mbar));
            end else begin
               r.opcode = 3'($urandom_range(0, 5));
            end
         end
         vfps_pkg::PH_EXEC: begin
            if (roll < 10)      r.opcode = vfps_pkg::OP_HOLD;
            else if (roll < 14) r.opcode = vfps_pkg::OP_STOP;
            else if (roll < 18) r.opcode = 3'($urandom_range(0, 4));
            // pressure usually still below target while filling
            if (sb.st.exec_step == vfps_pkg::STEP_FILL && $urandom_range(0, 99) < 70)
               r.pressure_mbar = 16'($urandom_range(0, sb.st.latched_setpoint));
         end
         vfps_pkg::PH_HELD: begin
            if (roll < 45)      r.opcode = vfps_pkg::OP_RESUME;
            else if (roll < 65) r.opcode = vfps_pkg::OP_STOP;
            else                r.opcode = 3'($urandom_range(0, 5));
         end
         vfps_pkg::PH_STOPPED: begin
            if (roll < 60) r.opcode = vfps_pkg::OP_RESET;
            else           r.opcode = 3'($urandom_range(0, 5));
         end
         vfps_pkg::PH_COMPLETE: begin
            if (roll < 30)      r.opcode = vfps_pkg::OP_RESET;
            else if (roll < 40) r.opcode = 3'($urandom_range(0, 5));
         end
         default: begin
            if (roll < 8)       r.opcode = vfps_pkg::OP_STOP;
            else if (roll < 14) r.opcode = 3'($urandom_range(0, 5));
         end
      endcase
      return r;
   endfunction

   initial begin
      vfps_pkg::state_type snap;
      sb           = new();
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      burst_left   = 0;
      stall_mode   = 0;
      stall_left   = 0;
      stall_cycle  = 0;
      total_items  = 0;
      active_items = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: ignored commands, start boundaries, hold/resume, fill, stop and reset paths
      send_cmd(vfps_pkg::OP_TICK,   16'h1234, 16'h0000, 1'b1);
      send_cmd(vfps_pkg::OP_HOLD,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_RESUME, 16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_START,  16'h1000, 16'hFFFF, 1'b0);
      send_cmd(OP_SPARE6,           16'hFFFF, 16'h0000, 1'b1);
      send_cmd(OP_SPARE7,           16'hFFFF, 16'hFFFF, 1'b1);
      send_cmd(vfps_pkg::OP_START,  16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_START,  16'hFFFF, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b1);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b1);
      send_cmd(vfps_pkg::OP_HOLD,   16'h0000, 16'h0000, 1'b1);
      send_cmd(vfps_pkg::OP_RESUME, 16'h0000, 16'h0000, 1'b1);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b1);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_RESUME, 16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b1);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0001, 1'b1);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'hFFFF, 1'b1);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'hFFFF, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_START,  16'hFFFF, 16'hFFFF, 1'b0);
      send_cmd(vfps_pkg::OP_STOP,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_RESET,  16'h0000, 16'h0000, 1'b0);
      send_cmd(vfps_pkg::OP_TICK,   16'h0000, 16'h0000, 1'b0);
      drain_results();

      // Random part up to the request budget; active_items counts state changes
      while (total_items < RANDOM_ITEMS) begin
         snap = sb.st;
         push_request(pick_command());
         if (sb.st != snap) active_items++;
         if (total_items % 400 == 0) drain_results();
      end
      req_valid = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      sb.failures += sb.pending();

      $display("Sent %0d commands (%0d changed state), checked %0d results, %0d fills completed.",
               total_items, active_items, sb.results_checked, sb.fills_done);
      $display("Command mix: start %0d hold %0d stop %0d reset %0d resume %0d tick %0d spare %0d",
               sb.op_seen[vfps_pkg::OP_START], sb.op_seen[vfps_pkg::OP_HOLD],
               sb.op_seen[vfps_pkg::OP_STOP], sb.op_seen[vfps_pkg::OP_RESET],
               sb.op_seen[vfps_pkg::OP_RESUME], sb.op_seen[vfps_pkg::OP_TICK],
               sb.op_seen[OP_SPARE6] + sb.op_seen[OP_SPARE7]);
      if (sb.failures == 0) begin
         $display("valve_fill_phase_sequencer_unit verification clean");
      end else begin
         $display("%0d failures", sb.failures);
         $display("valve_fill_phase_sequencer_unit verification failed");
      end
      $finish;
   end

endmodule

### valve_fill_phase_sequencer_unit.f
src/vfps_pkg.sv
src/vfps_in_stage.sv
src/vfps_next_state.sv
src/valve_fill_phase_sequencer_unit.sv
src/vfps_checker.sv
tb/sv/tb_valve_fill_phase_sequencer_unit.sv
